// File: rtl/srbu_pkg.sv
// shared types and constants for the strip readout block unpacker
`default_nettype none

package srbu_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_EXPECTED_MARKER = 2'd0;
    localparam logic [1:0] REG_STRIP_LIMIT     = 2'd1;

    // reset values of the configuration registers
    localparam logic [15:0] MARKER_RESET = 16'h1ff3;
    localparam logic [9:0]  LIMIT_RESET  = 10'd512;

    // parser phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_STRIPS = 2'd2;

    // header word positions that carry checks
    localparam logic [3:0] HPOS_MARKER = 4'd1;
    localparam logic [3:0] HPOS_LENGTH = 4'd2;
    localparam logic [3:0] HPOS_COUNT  = 4'd4;
    localparam logic [3:0] HPOS_LAST   = 4'd8;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MARKER    = 3'd1;
    localparam logic [2:0] ST_LENGTH    = 3'd2;
    localparam logic [2:0] ST_COUNT_MOD = 3'd3;
    localparam logic [2:0] ST_COUNT_MAX = 3'd4;
    localparam logic [2:0] ST_OVER_LIM  = 3'd5;
    localparam logic [2:0] ST_CHANNEL   = 3'd6;
    localparam logic [2:0] ST_BOARD     = 3'd7;

    // result kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [13:0] HARD_STRIP_MAX = 14'd512;
    localparam logic [5:0]  CHAN_MAX       = 6'd31;
    localparam logic [7:0]  BOARD_MAX      = 8'd8;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);

    typedef struct packed {
        logic        kind;
        logic [3:0]  board_number;
        logic [4:0]  channel_number;
        logic [15:0] energy_high;
        logic [15:0] energy_low;
        logic [15:0] hit_time;
        logic [2:0]  status;
        logic [9:0]  strips_done;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/strip_readout_block_unpacker_top.sv
// strip readout block unpacker: header checks, strip mapping and result queue
// results: a result is written into the registered result queue when the word that causes it is taken
// throughput: one word per cycle; a final strip beat pushes two results into a
// four-entry result queue, and s_ready drops while fewer than two entries are free
// reset: aresetn is synchronous and active low; it clears the parser, the queue and
// sets the marker and strip limit registers to their defaults
`default_nettype none

module strip_readout_block_unpacker_top
    import srbu_pkg::*;
#(
    parameter int MAX_STRIPS = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_word,
    input  wire logic        s_start_req,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [3:0]       m_board_number,
    output logic [4:0]       m_channel_number,
    output logic [15:0]      m_energy_high,
    output logic [15:0]      m_energy_low,
    output logic [15:0]      m_hit_time,
    output logic [2:0]       m_status,
    output logic [9:0]       m_strips_done,
    output logic             m_last
);

    localparam logic [9:0] MAX_STRIPS_W = 10'(MAX_STRIPS);

    logic [15:0] marker_reg;
    logic [9:0]  limit_reg;

    logic [1:0]  phase_reg,   phase_next;
    logic [3:0]  hpos_reg,    hpos_next;
    logic [9:0]  target_reg,  target_next;
    logic [9:0]  counter_reg, counter_next;
    logic [1:0]  rpos_reg,    rpos_next;
    logic [15:0] id_reg,      id_next;
    logic [15:0] high_reg,    high_next;
    logic [15:0] low_reg,     low_next;

    result_t               rq_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   head_reg, head_next;
    logic [RQ_PTR_W-1:0]   tail_reg, tail_next;
    logic [RQ_PTR_W:0]     count_reg, count_next;

    logic        s_fire, m_fire;
    logic        do_rec, do_fin;
    logic [2:0]  fin_status;
    logic [9:0]  eff_limit;
    logic [13:0] quarter;
    logic [7:0]  chip;
    logic [5:0]  chan_map;
    logic [7:0]  board_map;
    result_t     rec_res, fin_res, push0, push1;
    logic [1:0]  n_push;

    assign cfg_ready = 1'b1;
    assign s_ready   = (count_reg <= (RQ_PTR_W+1)'(RQ_DEPTH - 2));
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = (count_reg != '0);
    assign m_fire    = m_valid && m_ready;

    assign eff_limit = (limit_reg < MAX_STRIPS_W) ? limit_reg : MAX_STRIPS_W;
    assign quarter   = s_word[15:2];
    assign chip      = id_reg[12:5];
    assign chan_map  = {id_reg[4:0], chip[0]};
    assign board_map = {1'b0, chip[7:1]} + {7'd0, chip[0]};

    // parser
    always_comb begin
        phase_next   = phase_reg;
        hpos_next    = hpos_reg;
        target_next  = target_reg;
        counter_next = counter_reg;
        rpos_next    = rpos_reg;
        id_next      = id_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        do_rec       = 1'b0;
        do_fin       = 1'b0;
        fin_status   = ST_OK;

        if (s_fire) begin
            if (s_start_req) begin
                phase_next   = PH_HEADER;
                hpos_next    = HPOS_MARKER;
                target_next  = '0;
                counter_next = '0;
                rpos_next    = '0;
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        hpos_next = hpos_reg + 4'd1;
                        if (hpos_reg == HPOS_MARKER) begin
                            if (s_word != marker_reg) begin
                                do_fin     = 1'b1;
                                fin_status = ST_MARKER;
                            end
                        end else if (hpos_reg == HPOS_LENGTH) begin
                            if (s_word[15:11] != '0) begin
                                do_fin     = 1'b1;
                                fin_status = ST_LENGTH;
                            end
                        end else if (hpos_reg == HPOS_COUNT) begin
                            if (s_word[1:0] != 2'd0) begin
                                do_fin     = 1'b1;
                                fin_status = ST_COUNT_MOD;
                            end else if (quarter > HARD_STRIP_MAX) begin
                                do_fin     = 1'b1;
                                fin_status = ST_COUNT_MAX;
                            end else if (quarter > {4'd0, eff_limit}) begin
                                do_fin     = 1'b1;
                                fin_status = ST_OVER_LIM;
                            end else begin
                                target_next = quarter[9:0];
                            end
                        end else if (hpos_reg >= HPOS_LAST) begin
                            if (target_reg == '0) begin
                                do_fin     = 1'b1;
                                fin_status = ST_OK;
                            end else begin
                                phase_next = PH_STRIPS;
                                rpos_next  = '0;
                            end
                        end
                    end
                    PH_STRIPS: begin
                        rpos_next = rpos_reg + 2'd1;
                        case (rpos_reg)
                            2'd0: id_next   = s_word;
                            2'd1: high_next = s_word;
                            2'd2: low_next  = s_word;
                            default: begin
                                if (chan_map > CHAN_MAX) begin
                                    do_fin     = 1'b1;
                                    fin_status = ST_CHANNEL;
                                end else if (board_map > BOARD_MAX) begin
                                    do_fin     = 1'b1;
                                    fin_status = ST_BOARD;
                                end else begin
                                    do_rec       = 1'b1;
                                    counter_next = counter_reg + 10'd1;
                                    if (counter_next >= target_reg) begin
                                        do_fin     = 1'b1;
                                        fin_status = ST_OK;
                                    end
                                end
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
            if (do_fin) begin
                phase_next = PH_IDLE;
                hpos_next  = '0;
                rpos_next  = '0;
            end
        end
    end

    // result beats
    always_comb begin
        rec_res                = '0;
        rec_res.kind           = KIND_RECORD;
        rec_res.board_number   = board_map[3:0];
        rec_res.channel_number = chan_map[4:0];
        rec_res.energy_high    = high_reg;
        rec_res.energy_low     = low_reg;
        rec_res.hit_time       = s_word;
        rec_res.status         = ST_OK;
        rec_res.strips_done    = counter_next;
        rec_res.last           = 1'b0;

        fin_res             = '0;
        fin_res.kind        = KIND_STATUS;
        fin_res.status      = fin_status;
        fin_res.strips_done = counter_next;
        fin_res.last        = 1'b1;

        push0  = do_rec ? rec_res : fin_res;
        push1  = fin_res;
        n_push = {1'b0, do_rec} + {1'b0, do_fin};
    end

    always_comb begin
        tail_next  = tail_reg + RQ_PTR_W'(n_push);
        head_next  = m_fire ? head_reg + RQ_PTR_W'(1) : head_reg;
        count_next = count_reg + (RQ_PTR_W+1)'(n_push) - (RQ_PTR_W+1)'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= MARKER_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_EXPECTED_MARKER: marker_reg <= cfg_data;
                REG_STRIP_LIMIT:     limit_reg  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            hpos_reg    <= '0;
            target_reg  <= '0;
            counter_reg <= '0;
            rpos_reg    <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            hpos_reg    <= hpos_next;
            target_reg  <= target_next;
            counter_reg <= counter_next;
            rpos_reg    <= rpos_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
        end
    end

    // strip words and queue entries carry no reset
    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        high_reg <= high_next;
        low_reg  <= low_next;
        if (n_push != 2'd0) begin
            rq_mem[tail_reg] <= push0;
        end
        if (n_push == 2'd2) begin
            rq_mem[tail_reg + RQ_PTR_W'(1)] <= push1;
        end
    end

    assign m_kind           = rq_mem[head_reg].kind;
    assign m_board_number   = rq_mem[head_reg].board_number;
    assign m_channel_number = rq_mem[head_reg].channel_number;
    assign m_energy_high    = rq_mem[head_reg].energy_high;
    assign m_energy_low     = rq_mem[head_reg].energy_low;
    assign m_hit_time       = rq_mem[head_reg].hit_time;
    assign m_status         = rq_mem[head_reg].status;
    assign m_strips_done    = rq_mem[head_reg].strips_done;
    assign m_last           = rq_mem[head_reg].last;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (RQ_PTR_W+1)'(RQ_DEPTH))
        else $error("result queue overfilled");

    a_record_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_RECORD) |-> (!m_last && m_status == ST_OK))
        else $error("record beat carries status fields");

    a_start_enters_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_start_req) |=> (phase_reg == PH_HEADER && hpos_reg == HPOS_MARKER))
        else $error("start beat did not open a block");

    a_strip_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_STRIPS) |-> (counter_reg < target_reg))
        else $error("strip counter passed its target");

endmodule

`default_nettype wire

// File: bench/strip_readout_block_unpacker_top_tb.sv
// self-checking testbench for the strip readout block unpacker: random readout blocks, scoreboard
module strip_readout_block_unpacker_top_tb;
    import srbu_pkg::*;

    localparam int          STRIP_CAP     = 512;
    localparam logic [15:0] LENGTH_LIMIT  = 16'd2048;
    localparam int          SETTLE_CYCLES = 4;
    localparam logic [1:0]  REG_SPARE_2   = 2'd2;
    localparam logic [1:0]  REG_SPARE_3   = 2'd3;

    typedef enum {
        BLK_GOOD, BLK_BAD_MARKER, BLK_BAD_LENGTH, BLK_BAD_MOD, BLK_BAD_MAX,
        BLK_OVER_LIMIT, BLK_BAD_STRIP, BLK_ABANDON, BLK_NOISE
    } block_shape_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_word;
    logic        s_start_req;
    logic        m_valid;
    logic        m_ready;
    logic        m_kind;
    logic [3:0]  m_board_number;
    logic [4:0]  m_channel_number;
    logic [15:0] m_energy_high;
    logic [15:0] m_energy_low;
    logic [15:0] m_hit_time;
    logic [2:0]  m_status;
    logic [9:0]  m_strips_done;
    logic        m_last;

    strip_readout_block_unpacker_top #(.MAX_STRIPS(STRIP_CAP)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word), .s_start_req(s_start_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_board_number(m_board_number), .m_channel_number(m_channel_number),
        .m_energy_high(m_energy_high), .m_energy_low(m_energy_low), .m_hit_time(m_hit_time),
        .m_status(m_status), .m_strips_done(m_strips_done), .m_last(m_last)
    );

    // parser copy kept by the bench
    logic [15:0] marker_reg  = MARKER_RESET;
    logic [9:0]  limit_reg   = LIMIT_RESET;
    logic [1:0]  parse_phase = PH_IDLE;
    logic [3:0]  hdr_pos     = '0;
    logic [9:0]  strip_goal  = '0;
    logic [9:0]  strips_seen = '0;
    logic [1:0]  rec_pos     = '0;
    logic [15:0] held_id     = '0;
    logic [15:0] held_high   = '0;
    logic [15:0] held_low    = '0;

    result_t awaited_results[$];

    int  mismatches   = 0;
    int  words_parsed = 0;
    int  records_seen = 0;
    int  status_hits[8];
    bit  src_fast     = 1'b0;
    bit  rx_fast      = 1'b0;
    int  rx_hold      = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

    function automatic void close_block(input logic [2:0] code);
        result_t r;
        r = '0;
        r.kind        = KIND_STATUS;
        r.status      = code;
        r.strips_done = strips_seen;
        r.last        = 1'b1;
        awaited_results.push_back(r);
        parse_phase = PH_IDLE;
        hdr_pos     = '0;
        rec_pos     = '0;
    endfunction

    function automatic void parse_readout_word(input logic [15:0] w, input logic st);
        logic [3:0]  pos;
        logic [13:0] quarter;
        int          cap;
        logic [7:0]  chip;
        logic [7:0]  board8;
        logic [5:0]  chan6;
        result_t     r;
        if (st) begin
            parse_phase = PH_HEADER;
            hdr_pos     = HPOS_MARKER;
            strip_goal  = '0;
            strips_seen = '0;
            rec_pos     = '0;
        end else if (parse_phase == PH_HEADER) begin
            pos     = hdr_pos;
            hdr_pos = hdr_pos + 4'd1;
            if (pos == HPOS_MARKER) begin
                if (w != marker_reg) close_block(ST_MARKER);
            end else if (pos == HPOS_LENGTH) begin
                if (w >= LENGTH_LIMIT) close_block(ST_LENGTH);
            end else if (pos == HPOS_COUNT) begin
                quarter = w[15:2];
                cap = (int'(limit_reg) < STRIP_CAP) ? int'(limit_reg) : STRIP_CAP;
                if (w[1:0] != 2'b00) close_block(ST_COUNT_MOD);
                else if (quarter > HARD_STRIP_MAX) close_block(ST_COUNT_MAX);
                else if (int'(quarter) > cap) close_block(ST_OVER_LIM);
                else strip_goal = quarter[9:0];
            end else if (pos >= HPOS_LAST) begin
                if (strip_goal == '0) begin
                    close_block(ST_OK);
                end else begin
                    parse_phase = PH_STRIPS;
                    rec_pos     = '0;
                end
            end
        end else if (parse_phase == PH_STRIPS) begin
            case (rec_pos)
                2'd0: held_id   = w;
                2'd1: held_high = w;
                2'd2: held_low  = w;
                default: ;
            endcase
            rec_pos = rec_pos + 2'd1;
            if (rec_pos == 2'd0) begin
                // the time word completes the strip
                chip = held_id[12:5];
                if (!chip[0]) begin
                    chan6  = {held_id[4:0], 1'b0};
                    board8 = chip >> 1;
                end else begin
                    chan6  = {held_id[4:0], 1'b1};
                    board8 = (chip >> 1) + 8'd1;
                end
                if (chan6 > CHAN_MAX) begin
                    close_block(ST_CHANNEL);
                end else if (board8 > BOARD_MAX) begin
                    close_block(ST_BOARD);
                end else begin
                    strips_seen      = strips_seen + 10'd1;
                    r                = '0;
                    r.kind           = KIND_RECORD;
                    r.board_number   = board8[3:0];
                    r.channel_number = chan6[4:0];
                    r.energy_high    = held_high;
                    r.energy_low     = held_low;
                    r.hit_time       = w;
                    r.status         = ST_OK;
                    r.strips_done    = strips_seen;
                    awaited_results.push_back(r);
                    if (strips_seen >= strip_goal) close_block(ST_OK);
                end
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            if (mismatches < 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                if (mismatches < 10)
                    $display("result with nothing expected: kind %0d status %0d", m_kind,
                             m_status);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(m_kind));
                check_field("board_number", 16'(want.board_number), 16'(m_board_number));
                check_field("channel_number", 16'(want.channel_number),
                            16'(m_channel_number));
                check_field("energy_high", want.energy_high, m_energy_high);
                check_field("energy_low", want.energy_low, m_energy_low);
                check_field("hit_time", want.hit_time, m_hit_time);
                check_field("status", 16'(want.status), 16'(m_status));
                check_field("strips_done", 16'(want.strips_done), 16'(m_strips_done));
                check_field("last", 16'(want.last), 16'(m_last));
                if (want.kind == KIND_RECORD) records_seen++;
                else status_hits[want.status]++;
            end
        end
    end

    // result side: a random stall after each beat, plus long hold-offs on request
    initial begin : result_drain
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                stall_left = (rx_fast || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 14);
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // valid stays high from one beat to the next when there is no gap
    task automatic send_beat(input logic [15:0] w, input logic st);
        int gap;
        gap = 0;
        if (!src_fast && $urandom_range(0, 2) == 0) gap = $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_word      <= w;
        s_start_req <= st;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (st || parse_phase != PH_IDLE) words_parsed++;
        parse_readout_word(w, st);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_EXPECTED_MARKER: marker_reg = data;
            REG_STRIP_LIMIT:     limit_reg  = data[9:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] marker, input logic [15:0] limit_data);
        wait_idle();
        write_reg(REG_EXPECTED_MARKER, marker);
        // unused indexes must leave both registers alone
        if ($urandom_range(0, 1) == 1)
            write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
        write_reg(REG_STRIP_LIMIT, limit_data);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] good_strip_id();
        return {3'($urandom), 8'($urandom_range(0, 2 * int'(BOARD_MAX))),
                5'($urandom_range(0, int'(CHAN_MAX) / 2))};
    endfunction

    function automatic logic [15:0] bad_strip_id();
        if ($urandom_range(0, 1) == 1)
            return {3'($urandom), 8'($urandom), 5'($urandom_range(16, 31))};
        return {3'($urandom), 8'($urandom_range(2 * int'(BOARD_MAX) + 1, 255)),
                5'($urandom_range(0, int'(CHAN_MAX) / 2))};
    endfunction

    function automatic int pick_strip_count(input int cap);
        int r;
        int n;
        r = $urandom_range(0, 9);
        if (r < 2) n = 0;
        else if (r < 8) n = $urandom_range(1, 4);
        else n = $urandom_range(5, 12);
        return (n > cap) ? cap : n;
    endfunction

    task automatic send_header(input logic [15:0] count_word);
        send_beat(16'($urandom), 1'b1);
        send_beat(marker_reg, 1'b0);
        send_beat(16'($urandom_range(0, 2047)), 1'b0);
        send_beat(16'($urandom), 1'b0);
        send_beat(count_word, 1'b0);
        repeat (4) send_beat(16'($urandom), 1'b0);
    endtask

    task automatic send_block(input block_shape_t shape, input int strips_req, input int pause_at);
        logic [16:0] beats[$];
        logic [15:0] count_word;
        int          cap;
        int          n;
        int          bad_at;
        int          cut;
        cap = (int'(limit_reg) < STRIP_CAP) ? int'(limit_reg) : STRIP_CAP;
        if (shape == BLK_NOISE) begin
            repeat ($urandom_range(1, 3)) beats.push_back({1'b0, 16'($urandom)});
        end else begin
            n = (strips_req >= 0) ? strips_req : pick_strip_count(cap);
            if (shape == BLK_BAD_STRIP && n == 0) n = 1;
            bad_at = (n > 0) ? $urandom_range(0, n - 1) : 0;
            beats.push_back({1'b1, 16'($urandom)});
            if (shape == BLK_BAD_MARKER)
                beats.push_back({1'b0, marker_reg ^ 16'($urandom_range(1, 65535))});
            else
                beats.push_back({1'b0, marker_reg});
            if (shape == BLK_BAD_LENGTH)
                beats.push_back({1'b0, 16'($urandom_range(int'(LENGTH_LIMIT), 65535))});
            else
                beats.push_back({1'b0, 16'($urandom_range(0, int'(LENGTH_LIMIT) - 1))});
            beats.push_back({1'b0, 16'($urandom)});
            case (shape)
                BLK_BAD_MOD: count_word = {14'($urandom), 2'($urandom_range(1, 3))};
                BLK_BAD_MAX:
                    count_word = {14'($urandom_range(int'(HARD_STRIP_MAX) + 1, 16383)), 2'b00};
                BLK_OVER_LIMIT: begin
                    if (cap < STRIP_CAP)
                        count_word = {14'($urandom_range(cap + 1, STRIP_CAP)), 2'b00};
                    else
                        count_word = {14'($urandom_range(int'(HARD_STRIP_MAX) + 1, 16383)),
                                      2'b00};
                end
                default: count_word = 16'(n * 4);
            endcase
            beats.push_back({1'b0, count_word});
            repeat (4) beats.push_back({1'b0, 16'($urandom)});
            for (int i = 0; i < n; i++) begin
                if (shape == BLK_BAD_STRIP && i == bad_at)
                    beats.push_back({1'b0, bad_strip_id()});
                else
                    beats.push_back({1'b0, good_strip_id()});
                repeat (3) beats.push_back({1'b0, 16'($urandom)});
            end
            if (shape == BLK_ABANDON) begin
                // the next start cuts this block short
                cut = $urandom_range(1, beats.size() - 1);
                while (beats.size() > cut) beats.delete(beats.size() - 1);
            end
        end
        for (int i = 0; i < beats.size(); i++) begin
            if (i == pause_at) wait_idle();
            send_beat(beats[i][15:0], beats[i][16]);
        end
    endtask

    task automatic run_random_blocks(input int budget);
        int           first;
        int           pick;
        block_shape_t shape;
        first = words_parsed;
        while (words_parsed - first < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) shape = BLK_GOOD;
            else if (pick < 64) shape = BLK_BAD_MARKER;
            else if (pick < 68) shape = BLK_BAD_LENGTH;
            else if (pick < 72) shape = BLK_BAD_MOD;
            else if (pick < 76) shape = BLK_BAD_MAX;
            else if (pick < 80) shape = BLK_OVER_LIMIT;
            else if (pick < 90) shape = BLK_BAD_STRIP;
            else if (pick < 96) shape = BLK_ABANDON;
            else shape = BLK_NOISE;
            src_fast = ($urandom_range(0, 4) == 0);
            rx_fast  = ($urandom_range(0, 4) == 0);
            send_block(shape, -1, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 20) : -1);
        end
        src_fast = 1'b0;
        rx_fast  = 1'b0;
        if (parse_phase != PH_IDLE) send_block(BLK_GOOD, 0, -1);
    endtask

    task automatic test_directed_cases();
        // stray beats outside any block
        send_beat(16'h0000, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        // a new start drops the open block with no status
        send_beat(16'hFFFF, 1'b1);
        send_beat(marker_reg, 1'b0);
        send_beat(16'h0000, 1'b1);
        send_beat(~marker_reg, 1'b0);
        // length word right at the bound
        send_beat(16'h0001, 1'b1);
        send_beat(marker_reg, 1'b0);
        send_beat(LENGTH_LIMIT, 1'b0);
        // count not a multiple of four
        send_beat(16'h0002, 1'b1);
        send_beat(marker_reg, 1'b0);
        send_beat(LENGTH_LIMIT - 16'd1, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'd2, 1'b0);
        // one strip over the hard maximum
        send_beat(16'h0003, 1'b1);
        send_beat(marker_reg, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(16'((int'(HARD_STRIP_MAX) + 1) * 4), 1'b0);
        // empty block closes on the last header beat
        send_header(16'd0);
        // single strip: record and ok status from the same beat
        send_header(16'd4);
        send_beat({3'b111, 8'(2 * int'(BOARD_MAX)), 5'(int'(CHAN_MAX) / 2)}, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        wait_idle();
    endtask

    task automatic test_register_settings();
        apply_settings(16'h0000, 16'h0000);
        run_random_blocks(150);
        apply_settings(16'hFFFF, 16'h03FF);
        run_random_blocks(350);
        apply_settings(16'($urandom), 16'($urandom_range(1, 12)));
        run_random_blocks(350);
        apply_settings(16'($urandom), 16'hFE00);
        run_random_blocks(350);
        apply_settings(MARKER_RESET, 16'(LIMIT_RESET));
        run_random_blocks(350);
        wait_idle();
    endtask

    task automatic test_full_count();
        apply_settings(16'($urandom), 16'(LIMIT_RESET));
        send_header(16'(int'(HARD_STRIP_MAX) * 4));
        repeat (3) begin
            send_beat(good_strip_id(), 1'b0);
            repeat (3) send_beat(16'($urandom), 1'b0);
        end
        send_block(BLK_GOOD, 0, -1);
        apply_settings(marker_reg, 16'(LIMIT_RESET) - 16'd1);
        send_header(16'(int'(HARD_STRIP_MAX) * 4));
        wait_idle();
    endtask

    task automatic test_backpressure();
        // long hold-off with the sender pushing back to back
        rx_hold  = 300;
        src_fast = 1'b1;
        send_block(BLK_GOOD, 40, -1);
        src_fast = 1'b0;
        wait_idle();
    endtask

    task automatic test_pause_mid_block();
        send_block(BLK_GOOD, 6, 9 + 4 * 3);
        wait_idle();
    endtask

    initial begin : run_tests
        int status_total;
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_EXPECTED_MARKER;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_word      <= '0;
        s_start_req <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_register_settings();
        test_full_count();
        test_backpressure();
        test_pause_mid_block();
        wait_idle();

        if (awaited_results.size() != 0) begin
            $display("%0d results never arrived", awaited_results.size());
            mismatches++;
        end
        status_total = 0;
        foreach (status_hits[i]) status_total += status_hits[i];
        $display("parsed %0d readout words: %0d strip records, %0d block statuses",
                 words_parsed, records_seen, status_total);
        $display("statuses ok/marker/length/mod/max/limit/channel/board: %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
        $display("    %0d %0d %0d %0d",
                 status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
